@@ rtl/core/scfb_pkg.sv @@
// ----------------------------------------------------------------------------
// scfb_pkg
// Shared types, constants and the CRC16 byte update for the frame builder.
// ----------------------------------------------------------------------------
package scfb_pkg;

  localparam int unsigned SEQ_BITS_DEF = 15;
  localparam int unsigned HDR_BYTES    = 6;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;
  localparam logic [6:0]  SEQ_HI_MASK = 7'h7F;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_FINISH = 2'd2
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] frame_type;
    logic [7:0]  length_field;
    logic [7:0]  extra_byte;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_t;

  // CRC16-CCITT, MSB first, one byte per call
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/scfb_engine.sv @@
// ----------------------------------------------------------------------------
// scfb_engine
// Item register, byte index and frame state; picks one frame byte per step
// and folds each header and payload byte into the running CRC.
// ----------------------------------------------------------------------------
module scfb_engine #(
  parameter int unsigned SEQ_BITS = scfb_pkg::SEQ_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  scfb_pkg::in_t  in_data_i,
  input  logic           out_free_i,
  output logic           res_load_o,
  output scfb_pkg::out_t res_data_o
);
  import scfb_pkg::*;

  localparam int unsigned IdxW = $clog2(HDR_BYTES);

  in_t                 item_q;
  logic                item_vld_q;
  logic [IdxW-1:0]     idx_q;
  logic [SEQ_BITS-1:0] seq_q;
  logic [15:0]         crc_q;
  logic                in_frame_q;

  logic [IdxW:0]       nres;
  logic                emit;
  logic                last;
  logic                advance;
  logic                accept;
  logic [7:0]          byte_sel;
  logic [15:0]         seq_ext;
  logic [15:0]         crc_base;

  assign seq_ext = 16'(seq_q);

  always_comb begin
    nres = '0;
    case (item_q.action)
      ACT_START:  nres = (IdxW+1)'(HDR_BYTES);
      ACT_DATA:   nres = in_frame_q ? (IdxW+1)'(1) : '0;
      ACT_FINISH: nres = in_frame_q ? (IdxW+1)'(2) : '0;
      default:    nres = '0;
    endcase
  end

  assign emit    = (nres != '0);
  assign last    = !emit || ({1'b0, idx_q} == nres - (IdxW+1)'(1));
  assign advance = item_vld_q && (!emit || out_free_i);
  assign accept  = in_valid_i && in_ready_o;

  assign in_ready_o = !item_vld_q || (advance && last);

  always_comb begin
    byte_sel = 8'h00;
    case (item_q.action)
      ACT_START: begin
        case (idx_q)
          IdxW'(0): byte_sel = item_q.frame_type[15:8];
          IdxW'(1): byte_sel = item_q.frame_type[7:0];
          IdxW'(2): byte_sel = item_q.length_field;
          IdxW'(3): byte_sel = seq_ext[7:0];
          IdxW'(4): byte_sel = {1'b0, seq_ext[14:8] & SEQ_HI_MASK};
          default:  byte_sel = item_q.extra_byte;
        endcase
      end
      ACT_DATA:   byte_sel = item_q.data_byte;
      ACT_FINISH: byte_sel = (idx_q == '0) ? crc_q[7:0] : crc_q[15:8];
      default:    byte_sel = 8'h00;
    endcase
  end

  // first header byte restarts the CRC
  assign crc_base = (item_q.action == ACT_START && idx_q == '0) ? CRC_INIT : crc_q;

  assign res_load_o           = advance && emit;
  assign res_data_o.out_byte  = byte_sel;
  assign res_data_o.run_last  = last;
  assign res_data_o.frame_end = (item_q.action == ACT_FINISH) && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      idx_q      <= '0;
    end else if (accept) begin
      item_vld_q <= 1'b1;
      idx_q      <= '0;
    end else if (advance && last) begin
      item_vld_q <= 1'b0;
    end else if (advance) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= '0;
      crc_q      <= CRC_INIT;
      in_frame_q <= 1'b0;
    end else if (advance && emit) begin
      case (item_q.action)
        ACT_START: begin
          crc_q      <= crc_byte(crc_base, byte_sel);
          in_frame_q <= 1'b1;
        end
        ACT_DATA: crc_q <= crc_byte(crc_q, byte_sel);
        ACT_FINISH: begin
          if (last) begin
            crc_q      <= CRC_INIT;
            seq_q      <= seq_q + SEQ_BITS'(1);
            in_frame_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> item_vld_q && idx_q == '0)
    else $error("accepted word not loaded at index zero");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q |-> ({1'b0, idx_q} < (IdxW+1)'(HDR_BYTES)))
    else $error("byte index out of range");

  a_finish_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit && last && item_q.action == ACT_FINISH) |=>
      !in_frame_q && crc_q == CRC_INIT)
    else $error("frame not closed after CRC");

endmodule

@@ rtl/core/scfb_out_reg.sv @@
// ----------------------------------------------------------------------------
// scfb_out_reg
// Output register; holds a frame word until the sink takes it.
// ----------------------------------------------------------------------------
module scfb_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  scfb_pkg::out_t data_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output scfb_pkg::out_t out_data_o
);
  import scfb_pkg::*;

  out_t out_q;
  logic out_vld_q;

  assign free_o      = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_i) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q <= data_i;
    end
  end

  a_fend_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.frame_end) |-> out_q.run_last)
    else $error("frame end without run last");

endmodule

@@ rtl/core/sequenced_crc_frame_builder.sv @@
// ----------------------------------------------------------------------------
// sequenced_crc_frame_builder
// Frame byte stream builder: header, payload pass-through, CRC16 trailer.
//
//   channel  | dir | signals                               | payload
//   ---------+-----+---------------------------------------+---------
//   input    | in  | in_valid_i, in_ready_o, in_data_i     | in_t
//   output   | out | out_valid_o, out_ready_i, out_data_o  | out_t
//
// Start emits six header bytes, data one payload byte, finish two CRC bytes,
// ignored words none; the output register takes one byte per cycle while the sink is ready.
// The next word is taken in the cycle its predecessor hands over its last byte.
// Reset clears valids, sequence number, frame flag and sets the CRC to 0xFFFF.
// An output stall holds the engine; the held input word waits in its register.
// ----------------------------------------------------------------------------
module sequenced_crc_frame_builder #(
  parameter int unsigned SEQ_BITS = scfb_pkg::SEQ_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  scfb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output scfb_pkg::out_t out_data_o
);
  import scfb_pkg::*;

  logic  res_load;   // engine hands a word over this cycle
  logic  out_free;   // output register can take a word
  out_t  res_data;

  scfb_engine #(
    .SEQ_BITS (SEQ_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .res_data_o (res_data)
  );

  scfb_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .data_i      (res_data),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives start, payload and finish words into the frame builder and checks
// every output byte. Each byte is compared with a frame image that the bench
// computes itself: the header, the payload bytes and the CRC16 trailer. Both
// sides idle in short random bursts. One long output stall fills the block.
// ----------------------------------------------------------------------------
module testbench;
  import scfb_pkg::*;

  localparam int unsigned SEQ_W        = SEQ_BITS_DEF;
  localparam logic [1:0]  ACT_RESERVED = 2'd3;
  localparam int          CYCLE_LIMIT  = 100000;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          SETTLE       = 20;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // bench copy of the block state
  logic [SEQ_W-1:0] seq_q   = '0;
  logic [15:0]      crc_q   = CRC_INIT;
  bit               open_q  = 1'b0;

  out_t wire_bytes_q[$];
  int   fail_count  = 0;
  int   cycle_count = 0;
  bit   idle_on     = 1'b1;
  bit   hold_req    = 1'b0;
  int   hold_left   = 0;
  int   stall_left  = 0;

  sequenced_crc_frame_builder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // CRC16-CCITT, one data bit at a time, MSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void push_wire_byte(input logic [7:0] b, input logic last);
    out_t o;
    o.out_byte  = b;
    o.run_last  = last;
    o.frame_end = 1'b0;
    wire_bytes_q.push_back(o);
    crc_q = crc16_update(crc_q, b);
  endfunction

  function automatic void build_frame_bytes(input in_t w);
    int unsigned s;
    logic [7:0]  seq_hi;
    out_t        o;
    s      = 32'(seq_q);
    seq_hi = 8'(s >> 8) & {1'b0, SEQ_HI_MASK};
    case (w.action)
      ACT_START: begin
        // a start inside an open frame drops it; sequence stays
        crc_q  = CRC_INIT;
        open_q = 1'b1;
        push_wire_byte(w.frame_type[15:8], 1'b0);
        push_wire_byte(w.frame_type[7:0], 1'b0);
        push_wire_byte(w.length_field, 1'b0);
        push_wire_byte(8'(s), 1'b0);
        push_wire_byte(seq_hi, 1'b0);
        push_wire_byte(w.extra_byte, 1'b1);
      end
      ACT_DATA: begin
        if (open_q) begin
          push_wire_byte(w.data_byte, 1'b1);
        end
      end
      ACT_FINISH: begin
        if (open_q) begin
          o.out_byte  = crc_q[7:0];
          o.run_last  = 1'b0;
          o.frame_end = 1'b0;
          wire_bytes_q.push_back(o);
          o.out_byte  = crc_q[15:8];
          o.run_last  = 1'b1;
          o.frame_end = 1'b1;
          wire_bytes_q.push_back(o);
          seq_q  = seq_q + SEQ_W'(1);
          crc_q  = CRC_INIT;
          open_q = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic in_t mk_word(input logic [1:0] act, input logic [15:0] ftype,
                                  input logic [7:0] flen, input logic [7:0] extra,
                                  input logic [7:0] dbyte);
    in_t w;
    w.action       = action_e'(act);
    w.frame_type   = ftype;
    w.length_field = flen;
    w.extra_byte   = extra;
    w.data_byte    = dbyte;
    return w;
  endfunction

  function automatic in_t rand_word(input logic [1:0] act);
    return mk_word(act, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  task automatic send_word(input in_t w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    build_frame_bytes(w);
  endtask

  // output side: check the accepted byte, then decide next ready
  always @(posedge clk_i) begin : out_side
    out_t exp_b;
    if (out_valid_o && out_ready_i) begin
      if (wire_bytes_q.size() == 0) begin
        $error("unexpected byte %h", out_data_o.out_byte);
        fail_count++;
      end else begin
        exp_b = wire_bytes_q.pop_front();
        if (out_data_o.out_byte !== exp_b.out_byte) begin
          $error("out_byte: expected %h, got %h", exp_b.out_byte, out_data_o.out_byte);
          fail_count++;
        end
        if (out_data_o.run_last !== exp_b.run_last) begin
          $error("run_last: expected %b, got %b", exp_b.run_last, out_data_o.run_last);
          fail_count++;
        end
        if (out_data_o.frame_end !== exp_b.frame_end) begin
          $error("frame_end: expected %b, got %b", exp_b.frame_end, out_data_o.frame_end);
          fail_count++;
        end
      end
    end
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // payload and finish with no frame open, reserved action: no bytes out
  task automatic test_ignored_words();
    send_word(mk_word(ACT_DATA, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(mk_word(ACT_FINISH, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(mk_word(ACT_RESERVED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(mk_word(ACT_RESERVED, 16'h0000, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_header_extremes();
    send_word(mk_word(ACT_START, 16'h0000, 8'h00, 8'h00, 8'hFF));
    send_word(mk_word(ACT_FINISH, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_word(mk_word(ACT_START, 16'hFFFF, 8'hFF, 8'hFF, 8'h00));
    send_word(mk_word(ACT_DATA, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_word(mk_word(ACT_DATA, 16'h0000, 8'h00, 8'h00, 8'hFF));
    send_word(mk_word(ACT_RESERVED, 16'hA5A5, 8'h5A, 8'h5A, 8'h5A));
    send_word(mk_word(ACT_DATA, 16'h0000, 8'h00, 8'h00, 8'hA5));
    send_word(mk_word(ACT_FINISH, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // restart in mid frame: old frame dropped, header reuses the sequence
  task automatic test_abandoned_frame();
    send_word(mk_word(ACT_START, 16'h1234, 8'h03, 8'h42, 8'h00));
    send_word(mk_word(ACT_DATA, 16'h0000, 8'h00, 8'h00, 8'h11));
    send_word(mk_word(ACT_START, 16'h8001, 8'h01, 8'h7F, 8'h00));
    send_word(mk_word(ACT_START, 16'h8001, 8'h01, 8'h80, 8'h00));
    send_word(mk_word(ACT_DATA, 16'h0000, 8'h00, 8'h00, 8'h5A));
    send_word(mk_word(ACT_FINISH, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_word(mk_word(ACT_FINISH, 16'h0000, 8'h00, 8'h00, 8'h00));
    send_word(mk_word(ACT_DATA, 16'h0000, 8'h00, 8'h00, 8'h33));
  endtask

  task automatic send_random_frame(input int n_data);
    send_word(rand_word(ACT_START));
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_word(rand_word(ACT_RESERVED));
      end
      send_word(rand_word(ACT_DATA));
    end
    // now and then leave the frame open so the next start drops it
    if ($urandom_range(0, 11) != 0) begin
      send_word(rand_word(ACT_FINISH));
    end
  endtask

  task automatic test_random_frames(input int n_words);
    int sent;
    int n_data;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(rand_word(2'($urandom_range(0, 3))));
        sent++;
      end else begin
        n_data = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
        send_random_frame(n_data);
        sent += n_data + 2;
      end
    end
  endtask

  // receiver stalls long while frames keep coming
  task automatic test_output_hold();
    hold_req = 1'b1;
    for (int f = 0; f < 3; f++) begin
      send_random_frame(4);
    end
  endtask

  task automatic test_no_idle_tail();
    idle_on = 1'b0;
    test_random_frames(40);
  endtask

  initial begin : main
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_ignored_words();
    test_header_extremes();
    test_abandoned_frame();
    test_random_frames(200);
    test_output_hold();
    test_no_idle_tail();
    in_valid_i <= 1'b0;
    while (wire_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/scfb_pkg.sv
rtl/core/scfb_engine.sv
rtl/core/scfb_out_reg.sv
rtl/core/sequenced_crc_frame_builder.sv
bench/testbench.sv
